@@ sv/smr_pkg.sv @@
package smr_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SAMPLE_WIDTH     = 24;

   localparam int ROM_AW      = $clog2(SINE_TABLE_DEPTH);
   localparam int GAIN_W      = 17;
   localparam int PHASE_W     = 25;
   localparam int LEN_W       = 16;
   localparam int STEP_W      = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int LOOK_W      = PHASE_W + ROM_AW + 1;

   localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << STEP_W;
   localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(32768);
   localparam logic [63:0]        HALF_PI_Q31 = 64'd3373259426;

   localparam logic [CSR_INDEX_W-1:0] CSR_FALL_LENGTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEADY_LENGTH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_LENGTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALL_STEP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_STEP     = 3'd4;

   localparam logic [LEN_W-1:0]  FALL_LENGTH_RST   = 16'd240;
   localparam logic [LEN_W-1:0]  STEADY_LENGTH_RST = 16'd2400;
   localparam logic [LEN_W-1:0]  RISE_LENGTH_RST   = 16'd240;
   localparam logic [STEP_W-1:0] FALL_STEP_RST     = 24'd69905;
   localparam logic [STEP_W-1:0] RISE_STEP_RST     = 24'd69905;

   typedef enum logic [1:0] {
      ENV_PASS   = 2'd0,
      ENV_FALL   = 2'd1,
      ENV_STEADY = 2'd2,
      ENV_RISE   = 2'd3
   } env_mode_type;

   typedef enum logic [1:0] {
      GAIN_SEL_ZERO  = 2'd0,
      GAIN_SEL_UNITY = 2'd1,
      GAIN_SEL_TABLE = 2'd2
   } gain_sel_type;

   typedef struct packed {
      env_mode_type      phase;
      logic              done;
      gain_sel_type      sel;
      logic [ROM_AW-1:0] rom_addr;
   } env_info_type;

   typedef struct packed {
      logic                           action;
      logic signed [SAMPLE_WIDTH-1:0] main_left;
      logic signed [SAMPLE_WIDTH-1:0] main_right;
      logic signed [SAMPLE_WIDTH-1:0] aux_left;
      logic signed [SAMPLE_WIDTH-1:0] aux_right;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] out_main_left;
      logic signed [SAMPLE_WIDTH-1:0] out_main_right;
      logic signed [SAMPLE_WIDTH-1:0] out_aux_left;
      logic signed [SAMPLE_WIDTH-1:0] out_aux_right;
      logic [1:0]                     envelope_phase;
      logic                           switch_done;
   } rsp_word_type;

   typedef logic [15:0] rom_type [SINE_TABLE_DEPTH];

   // Q31 Taylor series of sin, rounded to Q15
   function automatic rom_type build_sine_rom();
      rom_type     t;
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         x = (HALF_PI_Q31 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
         term = x;
         sum = x;
         for (int k = 1; k <= 7; k++) begin
            term = (term * x) >> 31;
            term = (term * x) >> 31;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         sum = (sum + 64'd32768) >> 16;
         if (sum > 64'd32768) begin
            sum = 64'd32768;
         end
         t[i] = sum[15:0];
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_sine_rom();

endpackage

@@ sv/smr_gain_rom.sv @@
module smr_gain_rom (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [smr_pkg::ROM_AW-1:0] rd_addr,
   output logic [15:0]               rd_data
);

   logic [15:0] rom_mem [smr_pkg::SINE_TABLE_DEPTH];
   logic [15:0] rd_data_ff;

   assign rom_mem = smr_pkg::SINE_ROM;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/smr_lane.sv @@
module smr_lane (
   input  logic signed [smr_pkg::SAMPLE_WIDTH-1:0] sample,
   input  logic [smr_pkg::GAIN_W-1:0]              gain,
   output logic signed [smr_pkg::SAMPLE_WIDTH-1:0] result
);

   localparam int PROD_W = smr_pkg::SAMPLE_WIDTH + smr_pkg::GAIN_W + 1;

   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] rounded;

   // round half up, then floor by arithmetic shift
   always_comb begin
      prod    = PROD_W'(sample) * $signed({1'b0, gain});
      rounded = (prod + PROD_W'(16384)) >>> 15;
      result  = rounded[smr_pkg::SAMPLE_WIDTH-1:0];
   end

endmodule

@@ sv/smr_env.sv @@
module smr_env (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [smr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [smr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                accept,
   input  logic                                action,
   output smr_pkg::env_info_type               info
);

   smr_pkg::env_mode_type          mode_ff, mode_in;
   logic [smr_pkg::LEN_W-1:0]      count_ff, count_in;
   logic [smr_pkg::PHASE_W-1:0]    phase_ff, phase_in;

   logic [smr_pkg::LEN_W-1:0]      fall_length_ff, fall_length_in;
   logic [smr_pkg::LEN_W-1:0]      steady_length_ff, steady_length_in;
   logic [smr_pkg::LEN_W-1:0]      rise_length_ff, rise_length_in;
   logic [smr_pkg::STEP_W-1:0]     fall_step_ff, fall_step_in;
   logic [smr_pkg::STEP_W-1:0]     rise_step_ff, rise_step_in;

   logic [smr_pkg::STEP_W-1:0]     step;
   logic [smr_pkg::PHASE_W-1:0]    phase_sum;
   logic [smr_pkg::PHASE_W-1:0]    phase_adv;
   logic [smr_pkg::PHASE_W-1:0]    look;
   logic [smr_pkg::LOOK_W-1:0]     look_scaled;
   logic [smr_pkg::ROM_AW:0]       look_idx;
   logic [smr_pkg::LEN_W-1:0]      count_inc;
   logic [smr_pkg::LEN_W-1:0]      limit;
   logic                           wrap;

   always_comb begin
      fall_length_in   = fall_length_ff;
      steady_length_in = steady_length_ff;
      rise_length_in   = rise_length_ff;
      fall_step_in     = fall_step_ff;
      rise_step_in     = rise_step_ff;
      if (csr_we) begin
         case (csr_index)
            smr_pkg::CSR_FALL_LENGTH:   fall_length_in   = csr_wdata[smr_pkg::LEN_W-1:0];
            smr_pkg::CSR_STEADY_LENGTH: steady_length_in = csr_wdata[smr_pkg::LEN_W-1:0];
            smr_pkg::CSR_RISE_LENGTH:   rise_length_in   = csr_wdata[smr_pkg::LEN_W-1:0];
            smr_pkg::CSR_FALL_STEP:     fall_step_in     = csr_wdata[smr_pkg::STEP_W-1:0];
            smr_pkg::CSR_RISE_STEP:     rise_step_in     = csr_wdata[smr_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // advance phase, saturate at one; count the word and test for the end of the phase
   always_comb begin
      step      = (mode_ff == smr_pkg::ENV_FALL) ? fall_step_ff : rise_step_ff;
      phase_sum = phase_ff + smr_pkg::PHASE_W'(step);
      phase_adv = (phase_sum > smr_pkg::PHASE_ONE) ? smr_pkg::PHASE_ONE : phase_sum;
      count_inc = count_ff + smr_pkg::LEN_W'(1);
      case (mode_ff)
         smr_pkg::ENV_FALL:   limit = fall_length_ff;
         smr_pkg::ENV_STEADY: limit = steady_length_ff;
         smr_pkg::ENV_RISE:   limit = rise_length_ff;
         default:             limit = '0;
      endcase
      wrap = (count_inc >= limit);
   end

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      if (accept) begin
         if (action) begin
            mode_in  = smr_pkg::ENV_FALL;
            count_in = '0;
            phase_in = '0;
         end else if (mode_ff != smr_pkg::ENV_PASS) begin
            if (wrap) begin
               count_in = '0;
               phase_in = '0;
               case (mode_ff)
                  smr_pkg::ENV_FALL:   mode_in = smr_pkg::ENV_STEADY;
                  smr_pkg::ENV_STEADY: mode_in = smr_pkg::ENV_RISE;
                  default:             mode_in = smr_pkg::ENV_PASS;
               endcase
            end else begin
               count_in = count_inc;
               if (mode_ff != smr_pkg::ENV_STEADY) begin
                  phase_in = phase_adv;
               end
            end
         end
      end
   end

   always_comb begin
      look = (mode_ff == smr_pkg::ENV_FALL) ? smr_pkg::PHASE_ONE - phase_adv : phase_adv;
      look_scaled = smr_pkg::LOOK_W'(look) * smr_pkg::LOOK_W'(smr_pkg::SINE_TABLE_DEPTH);
      look_idx = look_scaled[smr_pkg::STEP_W +: (smr_pkg::ROM_AW + 1)];
      info.rom_addr = look_idx[smr_pkg::ROM_AW-1:0];
      info.done     = 1'b0;
      if (action) begin
         info.phase = smr_pkg::ENV_PASS;
         info.sel   = smr_pkg::GAIN_SEL_ZERO;
      end else begin
         info.phase = mode_ff;
         case (mode_ff)
            smr_pkg::ENV_FALL, smr_pkg::ENV_RISE: begin
               if (look_idx >= (smr_pkg::ROM_AW + 1)'(smr_pkg::SINE_TABLE_DEPTH)) begin
                  info.sel = smr_pkg::GAIN_SEL_UNITY;
               end else begin
                  info.sel = smr_pkg::GAIN_SEL_TABLE;
               end
               info.done = (mode_ff == smr_pkg::ENV_RISE) && wrap;
            end
            smr_pkg::ENV_STEADY: info.sel = smr_pkg::GAIN_SEL_ZERO;
            default:             info.sel = smr_pkg::GAIN_SEL_UNITY;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= smr_pkg::ENV_PASS;
         count_ff         <= '0;
         phase_ff         <= '0;
         fall_length_ff   <= smr_pkg::FALL_LENGTH_RST;
         steady_length_ff <= smr_pkg::STEADY_LENGTH_RST;
         rise_length_ff   <= smr_pkg::RISE_LENGTH_RST;
         fall_step_ff     <= smr_pkg::FALL_STEP_RST;
         rise_step_ff     <= smr_pkg::RISE_STEP_RST;
      end else begin
         mode_ff          <= mode_in;
         count_ff         <= count_in;
         phase_ff         <= phase_in;
         fall_length_ff   <= fall_length_in;
         steady_length_ff <= steady_length_in;
         rise_length_ff   <= rise_length_in;
         fall_step_ff     <= fall_step_in;
         rise_step_ff     <= rise_step_in;
      end
   end

endmodule

@@ sv/sine_ramp_switch_muter_unit.sv @@
// An accepted request word passes through the first-stage register, then the response register.
// Throughput: one word per cycle while rsp_stall is low; the envelope counters update in the accept cycle.
// The gain table read is registered in the first stage, the four lane multipliers
// feed the response register in the second.
// Reset (synchronous, active high) empties both stages, returns the envelope to
// pass-through and loads the register defaults; the gain table is constant.
module sine_ramp_switch_muter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  smr_pkg::req_word_type           req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output smr_pkg::rsp_word_type           rsp_word,
   input  logic                            csr_we,
   input  logic [smr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [smr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                          accept;
   logic                          rsp_load;
   logic                          st1_load;
   smr_pkg::env_info_type         info;
   logic [15:0]                   rom_data;
   logic [smr_pkg::GAIN_W-1:0]    gain;

   logic                          st1_valid_ff, st1_valid_in;
   smr_pkg::req_word_type         st1_word_ff;
   smr_pkg::env_info_type         st1_info_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   smr_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;

   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign st1_load  = !st1_valid_ff || rsp_load;
   assign req_stall = !st1_load;
   assign accept    = req_valid && st1_load;

   smr_env u_env (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .action    (req_word.action),
      .info      (info)
   );

   smr_gain_rom u_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (info.rom_addr),
      .rd_data (rom_data)
   );

   always_comb begin
      case (st1_info_ff.sel)
         smr_pkg::GAIN_SEL_UNITY: gain = smr_pkg::GAIN_ONE;
         smr_pkg::GAIN_SEL_TABLE: gain = {1'b0, rom_data};
         default:                 gain = '0;
      endcase
   end

   smr_lane u_lane_ml (
      .sample (st1_word_ff.main_left),
      .gain   (gain),
      .result (rsp_word_in.out_main_left)
   );

   smr_lane u_lane_mr (
      .sample (st1_word_ff.main_right),
      .gain   (gain),
      .result (rsp_word_in.out_main_right)
   );

   smr_lane u_lane_al (
      .sample (st1_word_ff.aux_left),
      .gain   (gain),
      .result (rsp_word_in.out_aux_left)
   );

   smr_lane u_lane_ar (
      .sample (st1_word_ff.aux_right),
      .gain   (gain),
      .result (rsp_word_in.out_aux_right)
   );

   assign rsp_word_in.envelope_phase = st1_info_ff.phase;
   assign rsp_word_in.switch_done    = st1_info_ff.done;

   always_comb begin
      st1_valid_in = st1_load ? req_valid : st1_valid_ff;
      rsp_valid_in = rsp_load ? st1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st1_valid_ff <= st1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st1_word_ff <= req_word;
         st1_info_ff <= info;
      end
      if (rsp_load && st1_valid_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> st1_valid_ff)
      else $error("accepted word did not reach the first stage");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (st1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_done_rise: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.switch_done) |->
      (rsp_word_ff.envelope_phase == smr_pkg::ENV_RISE))
      else $error("done flagged outside the rise phase");

   a_steady_mute: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.envelope_phase == smr_pkg::ENV_STEADY) |->
      (rsp_word_ff.out_main_left == '0 && rsp_word_ff.out_aux_right == '0))
      else $error("steady phase word not muted");

endmodule

@@ bench/sine_ramp_switch_muter_unit_tb.sv @@
module sine_ramp_switch_muter_unit_tb;

   localparam logic [16:0] UNITY_GAIN    = 17'd32768;
   localparam logic [24:0] FULL_PHASE    = 25'd16777216;
   localparam logic [63:0] HALF_PI_FIXED = 64'd3373259426;
   localparam int          RANDOM_WORDS  = 1350;
   localparam int          STALL_LIMIT   = 1000;
   localparam int          HOLD_CYCLES   = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid = 1'b0;
   logic                            req_stall;
   smr_pkg::req_word_type           req_word  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   smr_pkg::rsp_word_type           rsp_word;
   logic                            csr_we    = 1'b0;
   logic [smr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [smr_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   sine_ramp_switch_muter_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [15:0]           quarter_sine [smr_pkg::SINE_TABLE_DEPTH];
   smr_pkg::env_mode_type env_now   = smr_pkg::ENV_PASS;
   logic [15:0]           env_count = '0;
   logic [24:0]           env_phase = '0;
   logic [15:0]           fall_len   = 16'd240;
   logic [15:0]           steady_len = 16'd2400;
   logic [15:0]           rise_len   = 16'd240;
   logic [23:0]           fall_inc   = 24'd69905;
   logic [23:0]           rise_inc   = 24'd69905;

   smr_pkg::req_word_type pending_frames [$];
   smr_pkg::rsp_word_type expected_outputs [$];
   int  words_queued   = 0;
   int  words_accepted = 0;
   int  mismatches     = 0;
   int  stuck_cycles   = 0;
   int  holds_wanted   = 0;
   bit  req_fired      = 1'b0;
   bit  steady_flow    = 1'b0;

   function automatic logic [16:0] sine_gain(logic [24:0] p);
      logic [35:0] idx;
      idx = (36'(p) * 36'(smr_pkg::SINE_TABLE_DEPTH)) >> 24;
      if (idx >= 36'(smr_pkg::SINE_TABLE_DEPTH)) begin
         return UNITY_GAIN;
      end
      return {1'b0, quarter_sine[int'(idx)]};
   endfunction

   function automatic logic [smr_pkg::SAMPLE_WIDTH-1:0] weigh(
      logic signed [smr_pkg::SAMPLE_WIDTH-1:0] s, logic [16:0] g);
      longint p;
      p = longint'(s) * longint'(g);
      p = (p + 64'sd16384) >>> 15;
      return p[smr_pkg::SAMPLE_WIDTH-1:0];
   endfunction

   function automatic void advance_phase(logic [23:0] step);
      logic [25:0] s;
      s = 26'(env_phase) + 26'(step);
      if (s > 26'(FULL_PHASE)) begin
         s = 26'(FULL_PHASE);
      end
      env_phase = s[24:0];
   endfunction

   function automatic smr_pkg::rsp_word_type envelope_output(smr_pkg::req_word_type w);
      smr_pkg::rsp_word_type r;
      logic [16:0]           gain;
      smr_pkg::env_mode_type used;
      logic [15:0]           limit;
      logic                  done;
      r = '0;
      gain = UNITY_GAIN;
      used = env_now;
      limit = '0;
      done = 1'b0;
      if (w.action) begin
         env_now = smr_pkg::ENV_FALL;
         env_count = '0;
         env_phase = '0;
         return r;
      end
      case (used)
         smr_pkg::ENV_FALL: begin
            advance_phase(fall_inc);
            gain = sine_gain(FULL_PHASE - env_phase);
            limit = fall_len;
         end
         smr_pkg::ENV_STEADY: begin
            gain = '0;
            limit = steady_len;
         end
         smr_pkg::ENV_RISE: begin
            advance_phase(rise_inc);
            gain = sine_gain(env_phase);
            limit = rise_len;
         end
         default: ;
      endcase
      if (used != smr_pkg::ENV_PASS) begin
         env_count = env_count + 16'd1;
         if (env_count >= limit) begin
            env_count = '0;
            env_phase = '0;
            if (used == smr_pkg::ENV_RISE) begin
               env_now = smr_pkg::ENV_PASS;
               done = 1'b1;
            end else begin
               env_now = smr_pkg::env_mode_type'(used + 1);
            end
         end
      end
      r.out_main_left  = weigh(w.main_left, gain);
      r.out_main_right = weigh(w.main_right, gain);
      r.out_aux_left   = weigh(w.aux_left, gain);
      r.out_aux_right  = weigh(w.aux_right, gain);
      r.envelope_phase = used;
      r.switch_done    = done;
      return r;
   endfunction

   task automatic check_field(string what, logic [smr_pkg::SAMPLE_WIDTH-1:0] want,
                              logic [smr_pkg::SAMPLE_WIDTH-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
      end
   endtask

   // driver: hold a stalled word, otherwise advance or idle
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fired)) begin
         if (pending_frames.size() != 0 && (steady_flow || $urandom_range(99) >= 33)) begin
            req_word  <= pending_frames.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      int hold_left;
      int holds_done;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holds_done != holds_wanted) begin
         holds_done = holds_wanted;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady_flow && ($urandom_range(99) < 33);
      end
   end

   always @(posedge clock) begin : monitor
      smr_pkg::rsp_word_type want;
      req_fired = !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            mismatches++;
            $display("%0t unexpected word: expected none actual %h", $time, rsp_word);
         end else begin
            want = expected_outputs.pop_front();
            check_field("out_main_left", want.out_main_left, rsp_word.out_main_left);
            check_field("out_main_right", want.out_main_right, rsp_word.out_main_right);
            check_field("out_aux_left", want.out_aux_left, rsp_word.out_aux_left);
            check_field("out_aux_right", want.out_aux_right, rsp_word.out_aux_right);
            check_field("envelope_phase", 24'(want.envelope_phase),
                        24'(rsp_word.envelope_phase));
            check_field("switch_done", 24'(want.switch_done), 24'(rsp_word.switch_done));
         end
      end
      if (req_fired) begin
         expected_outputs.push_back(envelope_output(req_word));
         words_accepted++;
      end
      if (req_fired || (!reset && rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("sine_ramp_switch_muter_unit_tb NOT OK");
         $finish;
      end
   end

   function automatic logic [smr_pkg::SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_length();
      case ($urandom_range(19))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [23:0] pick_step(logic [15:0] len);
      int base;
      base = 32'h100_0000 / ((len == 0) ? 1 : int'(len));
      case ($urandom_range(9))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom);
         default: begin
            base = base + $urandom_range(0, 3);
            return (base > 32'hFF_FFFF) ? 24'hFFFFFF : 24'(base);
         end
      endcase
   endfunction

   function automatic int envelope_span(logic [15:0] f, logic [15:0] s, logic [15:0] r);
      int n;
      n = ((f == 0) ? 1 : int'(f)) + ((s == 0) ? 1 : int'(s)) + ((r == 0) ? 1 : int'(r));
      return (n > 80) ? $urandom_range(20, 80) : n;
   endfunction

   task automatic queue_word(logic act, logic [23:0] ml, logic [23:0] mr,
                             logic [23:0] al, logic [23:0] ar);
      smr_pkg::req_word_type w;
      w.action     = act;
      w.main_left  = ml;
      w.main_right = mr;
      w.aux_left   = al;
      w.aux_right  = ar;
      pending_frames.push_back(w);
      words_queued++;
   endtask

   task automatic queue_frame(logic act);
      queue_word(act, pick_sample(), pick_sample(), pick_sample(), pick_sample());
   endtask

   task automatic drain();
      while (words_accepted != words_queued || expected_outputs.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_register(logic [smr_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [smr_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         smr_pkg::CSR_FALL_LENGTH:   fall_len = val[15:0];
         smr_pkg::CSR_STEADY_LENGTH: steady_len = val[15:0];
         smr_pkg::CSR_RISE_LENGTH:   rise_len = val[15:0];
         smr_pkg::CSR_FALL_STEP:     fall_inc = val;
         smr_pkg::CSR_RISE_STEP:     rise_inc = val;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_envelope(logic [15:0] f, logic [15:0] s, logic [15:0] r,
                               logic [23:0] fs, logic [23:0] rs);
      write_register(smr_pkg::CSR_FALL_LENGTH, {8'($urandom), f});
      write_register(smr_pkg::CSR_STEADY_LENGTH, {8'($urandom), s});
      write_register(smr_pkg::CSR_RISE_LENGTH, {8'($urandom), r});
      write_register(smr_pkg::CSR_FALL_STEP, fs);
      write_register(smr_pkg::CSR_RISE_STEP, rs);
   endtask

   initial begin
      longint unsigned x, term, acc;
      logic [15:0]     f, s, r;
      int              phase_no, target, start_count, n, j;

      for (int i = 0; i < smr_pkg::SINE_TABLE_DEPTH; i++) begin
         x = (HALF_PI_FIXED * 64'(i)) / 64'(smr_pkg::SINE_TABLE_DEPTH);
         term = x;
         acc = x;
         for (int k = 1; k <= 7; k++) begin
            term = (term * x) >> 31;
            term = (term * x) >> 31;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
               acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
               acc = acc + term;
            end
         end
         acc = (acc + 64'd32768) >> 16;
         if (acc > 64'd32768) begin
            acc = 64'd32768;
         end
         quarter_sine[i] = acc[15:0];
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_word(1'b0, 24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF);
      queue_word(1'b0, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000000);
      queue_word(1'b0, 24'h000001, 24'hFFFFFE, 24'h555555, 24'hAAAAAA);
      queue_word(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      queue_word(1'b0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
      queue_frame(1'b0);
      queue_frame(1'b0);
      queue_frame(1'b0);
      drain();

      // shorten the fall while it is running
      set_envelope(16'd2, 16'd1, 16'd2, 24'hFFFFFF, 24'd0);
      end_writes();
      for (j = 0; j < 5; j++) begin
         queue_word(1'b0, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF);
      end
      queue_frame(1'b1);
      queue_frame(1'b1);
      queue_frame(1'b0);
      queue_frame(1'b1);
      queue_frame(1'b0);
      queue_frame(1'b0);
      drain();

      set_envelope(16'd0, 16'd0, 16'd0, 24'd1, 24'h800000);
      write_register(3'(smr_pkg::CSR_RISE_STEP + 1), 24'hFFFFFF);
      write_register(3'(smr_pkg::CSR_RISE_STEP + 2), 24'h000000);
      write_register(3'(smr_pkg::CSR_RISE_STEP + 3), 24'hA5A5A5);
      end_writes();
      queue_frame(1'b1);
      for (j = 0; j < 4; j++) begin
         queue_frame(1'b0);
      end

      phase_no = 0;
      start_count = words_queued;
      while (words_queued - start_count < RANDOM_WORDS) begin
         drain();
         steady_flow = (phase_no % 6) == 3;
         f = pick_length();
         s = pick_length();
         r = pick_length();
         if (phase_no == 2) begin
            f = 16'hFFFF;
            s = 16'hFFFF;
            r = 16'hFFFF;
         end
         set_envelope(f, s, r, pick_step(f), pick_step(r));
         if ($urandom_range(3) == 0) begin
            write_register(3'(smr_pkg::CSR_RISE_STEP + 1 + $urandom_range(2)),
                           24'($urandom));
         end
         end_writes();
         target = words_queued + (steady_flow ? 150 : $urandom_range(30, 70));
         while (words_queued < target) begin
            if ($urandom_range(99) < 85) begin
               queue_frame(1'b1);
               n = envelope_span(f, s, r) + $urandom_range(0, 3);
               for (j = 0; j < n; j++) begin
                  queue_frame(1'b0);
               end
            end else begin
               n = $urandom_range(1, 10);
               for (j = 0; j < n; j++) begin
                  queue_frame($urandom_range(99) < 30);
               end
            end
         end
         if (phase_no == 1) begin
            holds_wanted++;
         end
         phase_no++;
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_outputs.size() == 0) begin
         $display("sine_ramp_switch_muter_unit_tb OK");
      end else begin
         $display("sine_ramp_switch_muter_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
